>>> rtl/core/ocro_pkg.sv
// Package for the octree child ray order core.
// Holds widths, register codes and the request, result and pipeline types.
// Used by every other file of the block; depends on nothing.
package ocro_pkg;

  localparam int NumAxes   = 3;
  localparam int CoordW    = 32;
  localparam int FracW     = 16;
  localparam int NumW      = CoordW + 1 + FracW;
  localparam int ProdW     = 2 * CoordW;
  localparam int PointW    = ProdW - FracW + 1;
  localparam int DivBits   = 4;
  localparam int DivStages = CoordW / DivBits;
  localparam int RemW      = CoordW + 1;
  localparam int MaxHits   = 4;
  localparam int HitIdxW   = 2;
  localparam int CountW    = 3;
  localparam int ChildW    = 3;
  localparam int AddrW     = 5;
  localparam int RegIdxW   = 3;
  localparam int DataW     = 32;

  localparam logic [RegIdxW-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [RegIdxW-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [RegIdxW-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [RegIdxW-1:0] REG_DIR_X    = 3'd3;
  localparam logic [RegIdxW-1:0] REG_DIR_Y    = 3'd4;
  localparam logic [RegIdxW-1:0] REG_DIR_Z    = 3'd5;

  typedef logic signed [CoordW-1:0] fix_t;

  localparam fix_t DirXReset = 32'sh0001_0000;
  localparam fix_t FixMax    = 32'sh7fff_ffff;
  localparam fix_t FixMin    = 32'sh8000_0000;

  typedef struct packed {
    fix_t box_min_x;
    fix_t box_min_y;
    fix_t box_min_z;
    fix_t box_max_x;
    fix_t box_max_y;
    fix_t box_max_z;
    fix_t t_entry;
  } req_t;

  typedef struct packed {
    logic [CountW-1:0] hit_count;
    logic [ChildW-1:0] child0;
    logic [ChildW-1:0] child1;
    logic [ChildW-1:0] child2;
    logic [ChildW-1:0] child3;
    fix_t              t0;
    fix_t              t1;
    fix_t              t2;
    fix_t              t3;
  } res_t;

  typedef struct packed {
    fix_t [NumAxes-1:0] origin;
    fix_t [NumAxes-1:0] dir;
  } cfg_t;

  typedef struct packed {
    fix_t [NumAxes-1:0] bmin;
    fix_t [NumAxes-1:0] bmax;
    fix_t               t_in;
    logic [NumAxes-1:0] entry;
  } box_t;

  typedef struct packed {
    box_t               box;
    logic [NumAxes-1:0] neg;
    logic [NumAxes-1:0] dzero;
    logic [NumAxes-1:0] ovf;
  } side_t;

endpackage

>>> rtl/core/ocro_req_if.sv
// Request channel interface of the octree child ray order core.
// Carries valid, ready and one node query; depends on ocro_pkg.
interface ocro_req_if;
  import ocro_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/core/ocro_res_if.sv
// Result channel interface of the octree child ray order core.
// Carries valid, ready and one ordered child list; depends on ocro_pkg.
interface ocro_res_if;
  import ocro_pkg::*;
  logic valid;
  logic ready;
  res_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/core/ocro_cfg.sv
// APB register file holding the ray origin and direction.
// Depends on ocro_pkg.
module ocro_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ocro_pkg::AddrW-1:0] paddr,
  input  logic [ocro_pkg::DataW-1:0] pwdata,
  output logic [ocro_pkg::DataW-1:0] prdata,
  output logic                       pready,
  output ocro_pkg::cfg_t             cfg_o
);
  import ocro_pkg::*;

  fix_t [NumAxes-1:0] origin_q;
  fix_t [NumAxes-1:0] dir_q;
  logic [RegIdxW-1:0] idx;

  assign idx    = paddr[AddrW-1:2];
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q <= '0;
      dir_q    <= {fix_t'(0), fix_t'(0), DirXReset};
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_ORIGIN_X: origin_q[0] <= pwdata;
        REG_ORIGIN_Y: origin_q[1] <= pwdata;
        REG_ORIGIN_Z: origin_q[2] <= pwdata;
        REG_DIR_X:    dir_q[0] <= pwdata;
        REG_DIR_Y:    dir_q[1] <= pwdata;
        REG_DIR_Z:    dir_q[2] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ORIGIN_X: prdata = origin_q[0];
      REG_ORIGIN_Y: prdata = origin_q[1];
      REG_ORIGIN_Z: prdata = origin_q[2];
      REG_DIR_X:    prdata = dir_q[0];
      REG_DIR_Y:    prdata = dir_q[1];
      REG_DIR_Z:    prdata = dir_q[2];
      default:      prdata = '0;
    endcase
  end

  assign cfg_o.origin = origin_q;
  assign cfg_o.dir    = dir_q;

endmodule

>>> rtl/core/ocro_div.sv
// Pipelined restoring divider for one axis crossing distance.
// Retires four quotient bits per stage; depends on ocro_pkg.
module ocro_div (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [ocro_pkg::NumW-1:0]   num_i,
  input  logic [ocro_pkg::CoordW-1:0] den_i,
  output logic [ocro_pkg::CoordW-1:0] quo_o
);
  import ocro_pkg::*;

  logic [RemW-1:0]   rem_q [DivStages];
  logic [CoordW-1:0] low_q [DivStages];
  logic [CoordW-1:0] quo_q [DivStages];
  logic [CoordW-1:0] den_q [DivStages];

  for (genvar s = 0; s < DivStages; s++) begin : g_st
    logic [RemW-1:0]   r_in;
    logic [CoordW-1:0] n_in;
    logic [CoordW-1:0] q_in;
    logic [CoordW-1:0] dv;
    logic [RemW-1:0]   r;
    logic [CoordW-1:0] n;
    logic [CoordW-1:0] q;

    if (s == 0) begin : g_first
      assign r_in = RemW'(num_i[NumW-1:CoordW]);
      assign n_in = num_i[CoordW-1:0];
      assign q_in = '0;
      assign dv   = den_i;
    end else begin : g_next
      assign r_in = rem_q[s-1];
      assign n_in = low_q[s-1];
      assign q_in = quo_q[s-1];
      assign dv   = den_q[s-1];
    end

    always_comb begin
      r = r_in;
      n = n_in;
      q = q_in;
      for (int b = 0; b < DivBits; b++) begin
        r = {r[RemW-2:0], n[CoordW-1]};
        n = {n[CoordW-2:0], 1'b0};
        if (r >= {1'b0, dv}) begin
          r = r - {1'b0, dv};
          q = {q[CoordW-2:0], 1'b1};
        end else begin
          q = {q[CoordW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= r;
        low_q[s] <= n;
        quo_q[s] <= q;
        den_q[s] <= dv;
      end
    end
  end

  assign quo_o = quo_q[DivStages-1];

endmodule

>>> rtl/core/octree_child_ray_order_core.sv
// Octree child ray order core: for the ray held in the APB registers, each request
// carries one node box and the entry distance, and the result lists up to four child
// octants in ray order with their entry distances, all in signed Q16.16.
//
// Channels: req_i and res_o are valid/ready channels; a request is taken at a rising
// edge with valid and ready both high. The APB port writes and reads the origin and
// direction registers; the user must write them only while no request is in flight.
// The block itself does not enforce this.
// The result is registered through the input and setup stages, the eight divider
// stages, which retire four quotient bits each, and the saturation, multiply, box test
// and sort stages. One request is taken every cycle while the receiver does not stall.
//
// Reset clears all valid bits and sets the ray to the origin with direction +x.
// When the receiver stalls, the whole pipeline holds and req_i.ready goes low, so no
// request is lost or repeated; a free output register lets the pipeline keep moving.
module octree_child_ray_order_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  ocro_req_if.sink                   req_i,
  ocro_res_if.source                 res_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ocro_pkg::AddrW-1:0] paddr,
  input  logic [ocro_pkg::DataW-1:0] pwdata,
  output logic [ocro_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import ocro_pkg::*;

  cfg_t cfg;
  logic adv;

  ocro_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic out_valid_q;
  res_t out_q;

  assign adv         = ~out_valid_q | res_o.ready;
  assign req_i.ready = adv;
  assign res_o.valid = out_valid_q;
  assign res_o.payload = out_q;

  // Stage 1: mid-planes, numerators and entry products.
  fix_t [NumAxes-1:0]     bmin_c;
  fix_t [NumAxes-1:0]     bmax_c;
  fix_t [NumAxes-1:0]     mid_c;
  logic signed [NumW-1:0]  num_c [NumAxes];
  logic signed [ProdW-1:0] pe_c  [NumAxes];

  logic                    v1_q;
  box_t                    box1_q;
  fix_t [NumAxes-1:0]      mid1_q;
  logic signed [NumW-1:0]  num1_q [NumAxes];
  logic signed [ProdW-1:0] pe1_q  [NumAxes];

  assign bmin_c = {req_i.payload.box_min_z, req_i.payload.box_min_y,
                   req_i.payload.box_min_x};
  assign bmax_c = {req_i.payload.box_max_z, req_i.payload.box_max_y,
                   req_i.payload.box_max_x};

  always_comb begin
    logic [CoordW:0] sum;
    logic [CoordW:0] diff;
    for (int i = 0; i < NumAxes; i++) begin
      sum      = {bmin_c[i][CoordW-1], bmin_c[i]} + {bmax_c[i][CoordW-1], bmax_c[i]};
      mid_c[i] = sum[CoordW:1];
      diff     = {mid_c[i][CoordW-1], mid_c[i]} - {cfg.origin[i][CoordW-1], cfg.origin[i]};
      num_c[i] = {diff, {FracW{1'b0}}};
      pe_c[i]  = $signed({{CoordW{req_i.payload.t_entry[CoordW-1]}}, req_i.payload.t_entry})
               * $signed({{CoordW{cfg.dir[i][CoordW-1]}}, cfg.dir[i]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      box1_q.bmin  <= bmin_c;
      box1_q.bmax  <= bmax_c;
      box1_q.t_in  <= req_i.payload.t_entry;
      box1_q.entry <= '0;
      mid1_q       <= mid_c;
      for (int i = 0; i < NumAxes; i++) begin
        num1_q[i] <= num_c[i];
        pe1_q[i]  <= pe_c[i];
      end
    end
  end

  // Stage 2: entry octant and divider operand magnitudes.
  side_t                    side_c;
  logic [NumW-1:0]          nabs_c [NumAxes];
  logic [CoordW-1:0]        dabs_c [NumAxes];

  logic                     v2_q;
  side_t                    side2_q;
  logic [NumW-1:0]          nabs2_q [NumAxes];
  logic [CoordW-1:0]        dabs2_q [NumAxes];

  always_comb begin
    logic signed [PointW-1:0] pt;
    logic signed [PointW-1:0] mx;
    side_c     = '0;
    side_c.box = box1_q;
    for (int i = 0; i < NumAxes; i++) begin
      pt = $signed({{(PointW-CoordW){cfg.origin[i][CoordW-1]}}, cfg.origin[i]})
         + $signed({pe1_q[i][ProdW-1], pe1_q[i][ProdW-1:FracW]});
      mx = $signed({{(PointW-CoordW){mid1_q[i][CoordW-1]}}, mid1_q[i]});
      side_c.box.entry[i] = pt > mx;
      nabs_c[i] = num1_q[i][NumW-1] ? (~num1_q[i] + NumW'(1)) : num1_q[i];
      dabs_c[i] = cfg.dir[i][CoordW-1] ? (~cfg.dir[i] + CoordW'(1)) : cfg.dir[i];
      side_c.neg[i]   = num1_q[i][NumW-1] ^ cfg.dir[i][CoordW-1];
      side_c.dzero[i] = cfg.dir[i] == '0;
      side_c.ovf[i]   = CoordW'(nabs_c[i][NumW-1:CoordW]) >= dabs_c[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side2_q <= side_c;
      for (int i = 0; i < NumAxes; i++) begin
        nabs2_q[i] <= nabs_c[i];
        dabs2_q[i] <= dabs_c[i];
      end
    end
  end

  // Divider stages with a matching side line.
  logic [CoordW-1:0]    quo [NumAxes];
  logic [DivStages-1:0] vd_q;
  side_t                sd_q [DivStages];

  for (genvar a = 0; a < NumAxes; a++) begin : g_div
    ocro_div u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (nabs2_q[a]),
      .den_i (dabs2_q[a]),
      .quo_o (quo[a])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd_q[0] <= side2_q;
      for (int s = 1; s < DivStages; s++) begin
        sd_q[s] <= sd_q[s-1];
      end
    end
  end

  // Stage 3: saturation and the entry distance test.
  side_t              sdl;
  fix_t [NumAxes-1:0] tsat_c;
  logic [NumAxes-1:0] ok_c;

  logic               v3_q;
  box_t               box3_q;
  fix_t [NumAxes-1:0] t3_q;
  logic [NumAxes-1:0] ok3_q;

  assign sdl = sd_q[DivStages-1];

  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      if (sdl.ovf[a] || quo[a][CoordW-1]) begin
        tsat_c[a] = sdl.neg[a] ? FixMin : FixMax;
      end else begin
        tsat_c[a] = sdl.neg[a] ? (~quo[a] + CoordW'(1)) : quo[a];
      end
      ok_c[a] = !sdl.dzero[a] && (tsat_c[a] >= sdl.box.t_in);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      box3_q <= sdl.box;
      t3_q   <= tsat_c;
      ok3_q  <= ok_c;
    end
  end

  // Stage 4: crossing points on every axis.
  logic                    v4_q;
  box_t                    box4_q;
  fix_t [NumAxes-1:0]      t4_q;
  logic [NumAxes-1:0]      ok4_q;
  logic signed [ProdW-1:0] prod4_q [NumAxes][NumAxes];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      box4_q <= box3_q;
      t4_q   <= t3_q;
      ok4_q  <= ok3_q;
      for (int k = 0; k < NumAxes; k++) begin
        for (int i = 0; i < NumAxes; i++) begin
          prod4_q[k][i] <= $signed({{CoordW{t3_q[k][CoordW-1]}}, t3_q[k]})
                         * $signed({{CoordW{cfg.dir[i][CoordW-1]}}, cfg.dir[i]});
        end
      end
    end
  end

  // Stage 5: box test of the crossing points.
  logic [NumAxes-1:0] in_c;

  logic               v5_q;
  box_t               box5_q;
  fix_t [NumAxes-1:0] t5_q;
  logic [NumAxes-1:0] ok5_q;

  always_comb begin
    logic signed [PointW-1:0] p;
    logic signed [PointW-1:0] lo;
    logic signed [PointW-1:0] hi;
    for (int k = 0; k < NumAxes; k++) begin
      in_c[k] = 1'b1;
      for (int i = 0; i < NumAxes; i++) begin
        p  = $signed({{(PointW-CoordW){cfg.origin[i][CoordW-1]}}, cfg.origin[i]})
           + $signed({prod4_q[k][i][ProdW-1], prod4_q[k][i][ProdW-1:FracW]});
        lo = $signed({{(PointW-CoordW){box4_q.bmin[i][CoordW-1]}}, box4_q.bmin[i]});
        hi = $signed({{(PointW-CoordW){box4_q.bmax[i][CoordW-1]}}, box4_q.bmax[i]});
        if (p < lo || p > hi) begin
          in_c[k] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      box5_q <= box4_q;
      t5_q   <= t4_q;
      ok5_q  <= ok4_q & in_c;
    end
  end

  // Stage 6: ordering of the kept crossings and octant chaining.
  res_t res_c;

  always_comb begin
    logic [HitIdxW-1:0] rank;
    logic [HitIdxW-1:0] pos;
    logic [CountW-1:0]  cnt;
    logic [ChildW-1:0]  kid [MaxHits];
    fix_t               tt  [MaxHits];
    cnt = CountW'(1);
    for (int j = 0; j < MaxHits; j++) begin
      kid[j] = '0;
      tt[j]  = '0;
    end
    kid[0] = box5_q.entry;
    tt[0]  = box5_q.t_in;
    for (int a = 0; a < NumAxes; a++) begin
      cnt  = cnt + CountW'(ok5_q[a]);
      rank = '0;
      for (int b = 0; b < NumAxes; b++) begin
        if (b != a && ok5_q[b] &&
            (t5_q[b] < t5_q[a] || (t5_q[b] == t5_q[a] && b < a))) begin
          rank = rank + HitIdxW'(1);
        end
      end
      pos = rank + HitIdxW'(1);
      if (ok5_q[a]) begin
        kid[pos] = ChildW'(1) << a;
        tt[pos]  = t5_q[a];
      end
    end
    for (int j = 1; j < MaxHits; j++) begin
      if (CountW'(j) < cnt) begin
        kid[j] = kid[j] ^ kid[j-1];
      end
    end
    res_c.hit_count = cnt;
    res_c.child0    = kid[0];
    res_c.child1    = kid[1];
    res_c.child2    = kid[2];
    res_c.child3    = kid[3];
    res_c.t0        = tt[0];
    res_c.t1        = tt[1];
    res_c.t2        = tt[2];
    res_c.t3        = tt[3];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      vd_q        <= '0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= req_i.valid;
      v2_q        <= v1_q;
      vd_q        <= {vd_q[DivStages-2:0], v2_q};
      v3_q        <= vd_q[DivStages-1];
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      out_valid_q <= v5_q;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.hit_count >= CountW'(1) && out_q.hit_count <= CountW'(MaxHits)))
    else $error("hit count out of range");

  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.hit_count < CountW'(MaxHits))
      |-> (out_q.child3 == '0 && out_q.t3 == '0))
    else $error("unused fourth entry not cleared");

  a_order_1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.hit_count >= CountW'(2)) |-> (out_q.t1 >= out_q.t0))
    else $error("second child enters before the first");

  a_order_2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.hit_count >= CountW'(3)) |-> (out_q.t2 >= out_q.t1))
    else $error("third child enters before the second");

endmodule

>>> sim/ocro_order_checker.sv
// Checker for the octree child ray order core: follows the APB register writes,
// predicts each child list on request acceptance and compares every result.
// Depends on ocro_pkg and the ocro_req_if / ocro_res_if interfaces.
`timescale 1ns / 1ps
module ocro_order_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  ocro_req_if                        req,
  ocro_res_if                        res,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ocro_pkg::AddrW-1:0] paddr,
  input  logic [ocro_pkg::DataW-1:0] pwdata,
  input  logic                       pready,
  output int                         errors_o,
  output int                         pending_o,
  output int                         results_o
);
  import ocro_pkg::*;

  longint ray_org[3];
  longint ray_dir[3];
  res_t   child_lists[$];

  function automatic longint ray_point(int axis, longint t);
    return ray_org[axis] + ((t * ray_dir[axis]) >>> FracW);
  endfunction

  function automatic res_t order_children(req_t r);
    longint lo[3], hi[3], mid[3], tl[4], tin, t, p;
    logic [ChildW-1:0] kid[4];
    int n, pos;
    bit ok;
    res_t e;
    lo[0] = r.box_min_x; lo[1] = r.box_min_y; lo[2] = r.box_min_z;
    hi[0] = r.box_max_x; hi[1] = r.box_max_y; hi[2] = r.box_max_z;
    tin = r.t_entry;
    for (int i = 0; i < 4; i++) begin
      kid[i] = '0;
      tl[i] = 0;
    end
    for (int i = 0; i < 3; i++) begin
      mid[i] = (lo[i] + hi[i]) >>> 1;
      if (ray_point(i, tin) > mid[i]) kid[0][i] = 1'b1;
    end
    tl[0] = tin;
    n = 1;
    for (int a = 0; a < 3; a++) begin
      if (ray_dir[a] == 0) continue;
      t = ((mid[a] - ray_org[a]) * 65536) / ray_dir[a];
      if (t > 64'sd2147483647) t = 64'sd2147483647;
      if (t < -64'sd2147483648) t = -64'sd2147483648;
      if (t < tin) continue;
      ok = 1;
      for (int i = 0; i < 3; i++) begin
        p = ray_point(i, t);
        if (p < lo[i] || p > hi[i]) ok = 0;
      end
      if (!ok) continue;
      pos = n;
      for (int i = n - 1; i >= 1; i--) if (t < tl[i]) pos = i;
      for (int k = n; k > pos; k--) begin
        kid[k] = kid[k-1];
        tl[k] = tl[k-1];
      end
      kid[pos] = 3'b001 << a;
      tl[pos] = t;
      n++;
    end
    for (int i = 1; i < n; i++) kid[i] = kid[i] ^ kid[i-1];
    e.hit_count = n[CountW-1:0];
    e.child0 = kid[0]; e.child1 = kid[1]; e.child2 = kid[2]; e.child3 = kid[3];
    e.t0 = tl[0][31:0]; e.t1 = tl[1][31:0]; e.t2 = tl[2][31:0]; e.t3 = tl[3][31:0];
    return e;
  endfunction

  function automatic int check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $display("%0t: mismatch in %s: expected %h, actual %h", $time, name, exp, act);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t e, a;
    int bad;
    if (!rst_ni) begin
      ray_org[0] = 0; ray_org[1] = 0; ray_org[2] = 0;
      ray_dir[0] = 65536; ray_dir[1] = 0; ray_dir[2] = 0;
      child_lists.delete();
      errors_o = 0;
      results_o = 0;
    end else begin
      if (res.valid && res.ready) begin
        a = res.payload;
        results_o++;
        if (child_lists.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, a);
          errors_o++;
        end else begin
          e = child_lists.pop_front();
          bad = check_field("hit_count", e.hit_count, a.hit_count)
              + check_field("child0", e.child0, a.child0)
              + check_field("child1", e.child1, a.child1)
              + check_field("child2", e.child2, a.child2)
              + check_field("child3", e.child3, a.child3)
              + check_field("t0", e.t0, a.t0)
              + check_field("t1", e.t1, a.t1)
              + check_field("t2", e.t2, a.t2)
              + check_field("t3", e.t3, a.t3);
          if (bad != 0) errors_o++;
        end
      end
      if (req.valid && req.ready) child_lists = {child_lists, order_children(req.payload)};
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_ORIGIN_X: ray_org[0] = longint'($signed(pwdata));
          REG_ORIGIN_Y: ray_org[1] = longint'($signed(pwdata));
          REG_ORIGIN_Z: ray_org[2] = longint'($signed(pwdata));
          REG_DIR_X:    ray_dir[0] = longint'($signed(pwdata));
          REG_DIR_Y:    ray_dir[1] = longint'($signed(pwdata));
          REG_DIR_Z:    ray_dir[2] = longint'($signed(pwdata));
          default: ;
        endcase
      end
    end
    pending_o = child_lists.size();
  end
endmodule

>>> sim/octree_child_ray_order_core_tb.sv
// Testbench top for the octree child ray order core: drives node requests and APB
// register writes, throttles the result channel and gives the verdict.
// Depends on ocro_pkg, the channel interfaces, the core and ocro_order_checker.
`timescale 1ns / 1ps
module octree_child_ray_order_core_tb;
  import ocro_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int NumPhases  = 6;
  localparam int PerPhase   = 222;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic pready;
  int errors, pending, results, cycles;
  int items_sent;
  bit quiet, hold_req;

  ocro_req_if req ();
  ocro_res_if res ();

  octree_child_ray_order_core u_top (
    .clk_i, .rst_ni, .req_i(req), .res_o(res),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  ocro_order_checker u_checker (
    .clk_i, .rst_ni, .req(req), .res(res),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[octree_child_ray_order_core] ERROR");
      $finish;
    end
  end

  initial begin
    res.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        res.ready <= 1'b0;
        repeat (200) @(posedge clk_i);
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(0, 4)) @(posedge clk_i);
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  task automatic reg_write(logic [RegIdxW-1:0] idx, fix_t value);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= AddrW'(idx) << 2; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_ray(fix_t ox, fix_t oy, fix_t oz, fix_t dx, fix_t dy, fix_t dz);
    reg_write(REG_ORIGIN_X, ox);
    reg_write(REG_ORIGIN_Y, oy);
    reg_write(REG_ORIGIN_Z, oz);
    reg_write(REG_DIR_X, dx);
    reg_write(REG_DIR_Y, dy);
    reg_write(REG_DIR_Z, dz);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic send(req_t r);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.payload <= r;
    do @(posedge clk_i); while (!req.ready);
    items_sent++;
  endtask

  function automatic req_t cube(int cx, int cy, int cz, int h, int t);
    req_t r;
    r.box_min_x = (cx - h) <<< 16; r.box_max_x = (cx + h) <<< 16;
    r.box_min_y = (cy - h) <<< 16; r.box_max_y = (cy + h) <<< 16;
    r.box_min_z = (cz - h) <<< 16; r.box_max_z = (cz + h) <<< 16;
    r.t_entry = t <<< 16;
    return r;
  endfunction

  function automatic fix_t rnd_coord(int span);
    return fix_t'($signed($urandom_range(0, 2 * span))) - fix_t'(span);
  endfunction

  function automatic fix_t rnd_dir();
    if ($urandom_range(0, 4) == 0) return '0;
    return rnd_coord(2 << 16);
  endfunction

  function automatic req_t rnd_node();
    req_t r;
    fix_t h;
    if ($urandom_range(0, 3) == 0) begin
      r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      return r;
    end
    h = fix_t'($urandom_range(1 << 12, 8 << 16));
    r.box_min_x = rnd_coord(6 << 16); r.box_max_x = r.box_min_x + 2 * h;
    r.box_min_y = rnd_coord(6 << 16); r.box_max_y = r.box_min_y + 2 * h;
    r.box_min_z = rnd_coord(6 << 16); r.box_max_z = r.box_min_z + 2 * h;
    r.t_entry = rnd_coord(4 << 16);
    if ($urandom_range(0, 9) == 0) r.box_max_y = r.box_min_y - h;
    return r;
  endfunction

  initial begin
    req_t r;
    req.valid = 1'b0;
    req.payload = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(cube(0, 0, 0, 4, -8));
    send(cube(0, 0, 0, 4, 0));
    send(cube(2, 0, 0, 1, 0));
    r = '0; r.box_min_x = FixMin; r.box_min_y = FixMin; r.box_min_z = FixMin;
    r.box_max_x = FixMax; r.box_max_y = FixMax; r.box_max_z = FixMax;
    send(r);
    r.t_entry = FixMin; send(r);
    r.t_entry = FixMax; send(r);
    r = cube(0, 0, 0, 4, 0); r.box_min_x = 4 <<< 16; r.box_max_x = -(4 <<< 16); send(r);
    send('1);
    send('0);
    drain();
    set_ray(-(8 <<< 16), -(8 <<< 16), -(8 <<< 16), 1 <<< 16, 1 <<< 16, 1 <<< 16);
    send(cube(0, 0, 0, 4, 0));
    send(cube(0, 0, 0, 4, 8));
    send(cube(1, 0, -1, 4, 4));
    send(cube(0, 0, 0, 4, 20));
    drain();
    set_ray(FixMax, FixMin, FixMax, FixMin, FixMax, 32'sd1);
    send(cube(0, 0, 0, 4, 0));
    r = '0; r.box_min_x = FixMin; r.box_min_y = FixMin; r.box_min_z = FixMin;
    r.box_max_x = FixMax; r.box_max_y = FixMax; r.box_max_z = FixMax;
    send(r);
    for (int i = 0; i < 40; i++) send(rnd_node());
    drain();
    set_ray(0, 0, 0, '0, '0, FixMin);
    send(cube(0, 0, 0, 4, -2));
    send(cube(0, 0, 3, 4, 0));
    drain();

    for (int ph = 0; ph < NumPhases; ph++) begin
      set_ray(rnd_coord(8 << 16), rnd_coord(8 << 16), rnd_coord(8 << 16),
              rnd_dir(), rnd_dir(), rnd_dir());
      for (int i = 0; i < PerPhase; i++) begin
        if (ph == 1 && i == 50) hold_req = 1;
        if (ph == 2 && i == 100) begin
          req.valid <= 1'b0;
          while (pending != 0) @(posedge clk_i);
        end
        if (ph == NumPhases - 1 && i == PerPhase - 150) quiet = 1;
        send(rnd_node());
      end
      drain();
    end

    req.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    $display("Run covered %0d node requests and %0d child lists over %0d ray settings.",
             items_sent, results, NumPhases + 4);
    if (errors == 0) begin
      $display("[octree_child_ray_order_core] OK");
    end else begin
      $display("[octree_child_ray_order_core] ERROR");
    end
    $finish;
  end
endmodule

>>> files.f
rtl/core/ocro_pkg.sv
rtl/core/ocro_req_if.sv
rtl/core/ocro_res_if.sv
rtl/core/ocro_cfg.sv
rtl/core/ocro_div.sv
rtl/core/octree_child_ray_order_core.sv
sim/ocro_order_checker.sv
sim/octree_child_ray_order_core_tb.sv
